FILE: hw/rtl/ndl_pkg.sv
// Shared types and constants for the nearest-neighbor downscaler with luma output.
// Used by the stream interfaces, the shared divider and the top level.
`default_nettype none

package ndl_pkg;

  // Stream field widths
  localparam int PIX_W     = 8;
  localparam int COL_OUT_W = 10;
  localparam int ROW_OUT_W = 13;

  // Configuration port
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ORDER = 2'd2;

  // Limits
  localparam int MAX_OUT_WIDTH   = 640;
  localparam int MAX_FRAME_WIDTH = 8192;
  localparam int MIN_FRAME_WIDTH = 2;
  localparam int ROW_LIMIT       = 8192;

  // Internal widths
  localparam int FW_W   = 14;  // clamped full frame width
  localparam int HALF_W = 13;  // left half width
  localparam int FH_W   = 14;  // clamped frame height
  localparam int SRC_W  = 13;  // source column / row counters
  localparam int OW_W   = 10;  // output width, up to MAX_OUT_WIDTH
  localparam int OH_W   = 14;  // output height, up to ROW_LIMIT
  localparam int OROW_W = 14;  // output row counter, may reach the height itself
  localparam int NPC_W  = 14;  // next picked column
  localparam int NPR_W  = 16;  // next picked row
  localparam int CREM_W = 10;  // column accumulator remainder
  localparam int RREM_W = 13;  // row accumulator remainder
  localparam int CSQ_W  = 12;  // quotient of half row length / width
  localparam int CSTQ_W = 13;  // quotient of row length / width
  localparam int RSQ_W  = 13;  // quotient of half height / height
  localparam int RSTQ_W = 14;  // quotient of height / height

  // Shared divider
  localparam int DIV_N_W   = 23;
  localparam int DIV_D_W   = 14;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Luma weights, sum of weights is 256
  localparam int LUMA_SUM_W = 17;
  localparam int LUMA_SHIFT = 8;
  localparam logic [LUMA_SUM_W-1:0] LUMA_R     = LUMA_SUM_W'(77);
  localparam logic [LUMA_SUM_W-1:0] LUMA_G     = LUMA_SUM_W'(150);
  localparam logic [LUMA_SUM_W-1:0] LUMA_B     = LUMA_SUM_W'(29);
  localparam logic [LUMA_SUM_W-1:0] LUMA_ROUND = LUMA_SUM_W'(128);

endpackage

`default_nettype wire

FILE: hw/rtl/ndl_pix_if.sv
// Input pixel stream: valid/ready handshake carrying one 24-bit pixel a beat.
// Depends on ndl_pkg for field widths.
`default_nettype none

interface ndl_pix_if import ndl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] byte_zero;
  logic [PIX_W-1:0] byte_one;
  logic [PIX_W-1:0] byte_two;
  logic             frame_start;

  modport source (output valid, output byte_zero, output byte_one, output byte_two,
                  output frame_start, input ready);
  modport sink   (input valid, input byte_zero, input byte_one, input byte_two,
                  input frame_start, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ndl_luma_if.sv
// Output luma stream: valid/ready handshake carrying one sampled pixel a beat.
// Depends on ndl_pkg for field widths.
`default_nettype none

interface ndl_luma_if import ndl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     gray;
  logic [COL_OUT_W-1:0] out_column;
  logic [ROW_OUT_W-1:0] out_row;
  logic                 frame_end;

  modport source (output valid, output gray, output out_column, output out_row,
                  output frame_end, input ready);
  modport sink   (input valid, input gray, input out_column, input out_row,
                  input frame_end, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nearest_downscale_luma_unit.sv
// Nearest-neighbor downscaler of the left half of a side-by-side frame, with luma output.
// A pixel waits in the input stage, its result beat in the output register; one pixel per
// clock sustained unless a table rebuild or an output stall holds the flow. Division tables
// come from one shared bit-serial divider, 9 divisions, ready low after reset and every write.
// Reset (synchronous, active high) loads frame_width 2, frame_height 1, channel_order 0,
// clears all counters and empties both pipeline stages. Depends on ndl_pkg, ndl_div, ndl_*_if.
`default_nettype none

module nearest_downscale_luma_unit import ndl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_enable,
  input  logic [CFG_IDX_W-1:0] write_index,
  input  logic [CFG_W-1:0]     write_data,
  ndl_pix_if.sink              pixel,
  ndl_luma_if.source           luma
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             channel_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= CFG_W'(MIN_FRAME_WIDTH);
      frame_height  <= CFG_W'(1);
      channel_order <= 1'b0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_FRAME_WIDTH:   frame_width   <= write_data;
        REG_FRAME_HEIGHT:  frame_height  <= write_data;
        REG_CHANNEL_ORDER: channel_order <= write_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into their working ranges.
  logic [FW_W-1:0]   eff_width;
  logic [HALF_W-1:0] half_width;
  logic [FH_W-1:0]   eff_height;
  logic [OW_W-1:0]   new_out_width;

  always_comb begin
    if (frame_width < CFG_W'(MIN_FRAME_WIDTH)) begin
      eff_width = FW_W'(MIN_FRAME_WIDTH);
    end else if (frame_width > CFG_W'(MAX_FRAME_WIDTH)) begin
      eff_width = FW_W'(MAX_FRAME_WIDTH);
    end else begin
      eff_width = FW_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_height = FH_W'(1);
    end else if (frame_height > CFG_W'(ROW_LIMIT)) begin
      eff_height = FH_W'(ROW_LIMIT);
    end else begin
      eff_height = FH_W'(frame_height);
    end
    half_width    = eff_width[FW_W-1:1];
    new_out_width = (half_width < HALF_W'(MAX_OUT_WIDTH)) ? half_width[OW_W-1:0]
                                                          : OW_W'(MAX_OUT_WIDTH);
  end

  // ---------------------------------------------------------------------------
  // Division table sequencer.
  // "new" entries serve a frame that starts now (output size from the registers);
  // "cur" entries serve the running frame (output size as latched at its start).
  // Both sets follow the present registers for the row length and row count.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} seq_state_t;
  typedef enum logic [3:0] {
    DS_OUT_HEIGHT,
    DS_COL_START_NEW, DS_COL_STEP_NEW, DS_ROW_START_NEW, DS_ROW_STEP_NEW,
    DS_COL_START_CUR, DS_COL_STEP_CUR, DS_ROW_START_CUR, DS_ROW_STEP_CUR
  } div_step_t;

  seq_state_t state;
  div_step_t  step;
  logic       busy;

  logic [OW_W-1:0] derived_out_width;
  logic [OH_W-1:0] derived_out_height;
  logic [OH_W-1:0] new_out_height;

  logic [CSQ_W-1:0]  new_col_start_q, cur_col_start_q;
  logic [CREM_W-1:0] new_col_start_r, cur_col_start_r;
  logic [CSTQ_W-1:0] new_col_step_q,  cur_col_step_q;
  logic [CREM_W-1:0] new_col_step_r,  cur_col_step_r;
  logic [RSQ_W-1:0]  new_row_start_q, cur_row_start_q;
  logic [RREM_W-1:0] new_row_start_r, cur_row_start_r;
  logic [RSTQ_W-1:0] new_row_step_q,  cur_row_step_q;
  logic [RREM_W-1:0] new_row_step_r,  cur_row_step_r;

  logic               div_start;
  logic               div_done;
  logic [DIV_N_W-1:0] div_dividend;
  logic [DIV_D_W-1:0] div_divisor;
  logic [DIV_N_W-1:0] div_quo;
  logic [DIV_D_W-1:0] div_rem;
  logic [23:0]        height_num;
  logic               frame_go;

  assign busy      = state != ST_IDLE;
  assign div_start = state == ST_ISSUE;

  // Rounded output height numerator: height * out_width + half_width / 2.
  assign height_num = 24'(eff_height) * 24'(new_out_width) + 24'(half_width >> 1);

  always_comb begin
    unique case (step)
      DS_OUT_HEIGHT: begin
        div_dividend = height_num[DIV_N_W-1:0];
        div_divisor  = DIV_D_W'(half_width);
      end
      DS_COL_START_NEW: begin
        div_dividend = DIV_N_W'(half_width >> 1);
        div_divisor  = DIV_D_W'(new_out_width);
      end
      DS_COL_STEP_NEW: begin
        div_dividend = DIV_N_W'(half_width);
        div_divisor  = DIV_D_W'(new_out_width);
      end
      DS_ROW_START_NEW: begin
        div_dividend = DIV_N_W'(eff_height >> 1);
        div_divisor  = new_out_height;
      end
      DS_ROW_STEP_NEW: begin
        div_dividend = DIV_N_W'(eff_height);
        div_divisor  = new_out_height;
      end
      DS_COL_START_CUR: begin
        div_dividend = DIV_N_W'(half_width >> 1);
        div_divisor  = DIV_D_W'(derived_out_width);
      end
      DS_COL_STEP_CUR: begin
        div_dividend = DIV_N_W'(half_width);
        div_divisor  = DIV_D_W'(derived_out_width);
      end
      DS_ROW_START_CUR: begin
        div_dividend = DIV_N_W'(eff_height >> 1);
        div_divisor  = derived_out_height;
      end
      DS_ROW_STEP_CUR: begin
        div_dividend = DIV_N_W'(eff_height);
        div_divisor  = derived_out_height;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIV_D_W'(1);
      end
    endcase
  end

  ndl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  // Sequencer state and the latched output size of the running frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_ISSUE;
      step               <= DS_OUT_HEIGHT;
      derived_out_width  <= OW_W'(1);
      derived_out_height <= OH_W'(1);
    end else begin
      if (frame_go) begin
        derived_out_width  <= new_out_width;
        derived_out_height <= new_out_height;
      end
      if (write_enable) begin
        // Restart the whole pass on any write.
        state <= ST_ISSUE;
        step  <= DS_OUT_HEIGHT;
      end else begin
        unique case (state)
          ST_IDLE: ;
          ST_ISSUE: state <= ST_WAIT;
          ST_WAIT: begin
            if (div_done) begin
              if (step == DS_ROW_STEP_CUR) begin
                state <= ST_IDLE;
              end else begin
                state <= ST_ISSUE;
                step  <= div_step_t'(step + 1);
              end
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  // Table entries: filled by the divider, "cur" copied from "new" when a frame starts.
  always_ff @(posedge clk) begin
    if (frame_go) begin
      cur_col_start_q <= new_col_start_q;
      cur_col_start_r <= new_col_start_r;
      cur_col_step_q  <= new_col_step_q;
      cur_col_step_r  <= new_col_step_r;
      cur_row_start_q <= new_row_start_q;
      cur_row_start_r <= new_row_start_r;
      cur_row_step_q  <= new_row_step_q;
      cur_row_step_r  <= new_row_step_r;
    end else if (state == ST_WAIT && div_done) begin
      unique case (step)
        DS_OUT_HEIGHT:
          new_out_height <= (div_quo == '0) ? OH_W'(1) : div_quo[OH_W-1:0];
        DS_COL_START_NEW: begin
          new_col_start_q <= div_quo[CSQ_W-1:0];
          new_col_start_r <= div_rem[CREM_W-1:0];
        end
        DS_COL_STEP_NEW: begin
          new_col_step_q <= div_quo[CSTQ_W-1:0];
          new_col_step_r <= div_rem[CREM_W-1:0];
        end
        DS_ROW_START_NEW: begin
          new_row_start_q <= div_quo[RSQ_W-1:0];
          new_row_start_r <= div_rem[RREM_W-1:0];
        end
        DS_ROW_STEP_NEW: begin
          new_row_step_q <= div_quo[RSTQ_W-1:0];
          new_row_step_r <= div_rem[RREM_W-1:0];
        end
        DS_COL_START_CUR: begin
          cur_col_start_q <= div_quo[CSQ_W-1:0];
          cur_col_start_r <= div_rem[CREM_W-1:0];
        end
        DS_COL_STEP_CUR: begin
          cur_col_step_q <= div_quo[CSTQ_W-1:0];
          cur_col_step_r <= div_rem[CREM_W-1:0];
        end
        DS_ROW_START_CUR: begin
          cur_row_start_q <= div_quo[RSQ_W-1:0];
          cur_row_start_r <= div_rem[RREM_W-1:0];
        end
        DS_ROW_STEP_CUR: begin
          cur_row_step_q <= div_quo[RSTQ_W-1:0];
          cur_row_step_r <= div_rem[RREM_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: hold one pixel beat.
  // ---------------------------------------------------------------------------
  logic             pix_valid;
  logic [PIX_W-1:0] pix_byte_zero;
  logic [PIX_W-1:0] pix_byte_one;
  logic [PIX_W-1:0] pix_byte_two;
  logic             pix_frame_start;

  logic in_accept;
  logic out_free;
  logic hit;
  logic pix_go;

  assign out_free    = !luma.valid || luma.ready;
  // A pixel that gives no result never waits on the output side.
  assign pix_go      = pix_valid && (!hit || out_free);
  assign pixel.ready = !busy && (!pix_valid || pix_go);
  assign in_accept   = pixel.valid && pixel.ready;
  assign frame_go    = pix_go && pix_frame_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (in_accept) begin
      pix_valid <= 1'b1;
    end else if (pix_go) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix_byte_zero   <= pixel.byte_zero;
      pix_byte_one    <= pixel.byte_one;
      pix_byte_two    <= pixel.byte_two;
      pix_frame_start <= pixel.frame_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Sampling counters
  // ---------------------------------------------------------------------------
  logic [SRC_W-1:0]  source_column, source_row;
  logic [NPC_W-1:0]  next_pick_column;
  logic [NPR_W-1:0]  next_pick_row;
  logic [OW_W-1:0]   output_column;
  logic [OROW_W-1:0] output_row;
  logic [CREM_W-1:0] column_remainder;
  logic [RREM_W-1:0] row_remainder;

  logic [SRC_W-1:0]  source_column_next, source_row_next;
  logic [NPC_W-1:0]  next_pick_column_next;
  logic [NPR_W-1:0]  next_pick_row_next;
  logic [OW_W-1:0]   output_column_next;
  logic [OROW_W-1:0] output_row_next;
  logic [CREM_W-1:0] column_remainder_next;
  logic [RREM_W-1:0] row_remainder_next;

  // View of the counters and tables for the pixel at hand: a frame start sees a
  // freshly started frame.
  logic [SRC_W-1:0]  v_sc, v_sr;
  logic [NPC_W-1:0]  v_npc;
  logic [NPR_W-1:0]  v_npr;
  logic [OW_W-1:0]   v_oc;
  logic [OROW_W-1:0] v_orow;
  logic [CREM_W-1:0] v_cr;
  logic [RREM_W-1:0] v_rr;
  logic [OW_W-1:0]   v_dw;
  logic [OH_W-1:0]   v_dh;
  logic [CSQ_W-1:0]  v_col_start_q;
  logic [CREM_W-1:0] v_col_start_r;
  logic [CSTQ_W-1:0] v_col_step_q;
  logic [CREM_W-1:0] v_col_step_r;
  logic [RSQ_W-1:0]  v_row_start_q;
  logic [RREM_W-1:0] v_row_start_r;
  logic [RSTQ_W-1:0] v_row_step_q;
  logic [RREM_W-1:0] v_row_step_r;

  logic              row_hit, col_hit, row_end, last_row, is_last;
  logic [CREM_W:0]   col_sum;
  logic              col_wrap;
  logic [NPC_W-1:0]  npc_adv;
  logic [CREM_W-1:0] cr_adv;
  logic [RREM_W:0]   row_sum;
  logic              row_wrap;
  logic [NPR_W-1:0]  npr_adv;
  logic [RREM_W-1:0] rr_adv;

  always_comb begin
    if (pix_frame_start) begin
      v_sc          = '0;
      v_sr          = '0;
      v_oc          = '0;
      v_orow        = '0;
      v_npc         = NPC_W'(new_col_start_q);
      v_cr          = new_col_start_r;
      v_npr         = NPR_W'(new_row_start_q);
      v_rr          = new_row_start_r;
      v_dw          = new_out_width;
      v_dh          = new_out_height;
      v_col_start_q = new_col_start_q;
      v_col_start_r = new_col_start_r;
      v_col_step_q  = new_col_step_q;
      v_col_step_r  = new_col_step_r;
      v_row_start_q = new_row_start_q;
      v_row_start_r = new_row_start_r;
      v_row_step_q  = new_row_step_q;
      v_row_step_r  = new_row_step_r;
    end else begin
      v_sc          = source_column;
      v_sr          = source_row;
      v_oc          = output_column;
      v_orow        = output_row;
      v_npc         = next_pick_column;
      v_cr          = column_remainder;
      v_npr         = next_pick_row;
      v_rr          = row_remainder;
      v_dw          = derived_out_width;
      v_dh          = derived_out_height;
      v_col_start_q = cur_col_start_q;
      v_col_start_r = cur_col_start_r;
      v_col_step_q  = cur_col_step_q;
      v_col_step_r  = cur_col_step_r;
      v_row_start_q = cur_row_start_q;
      v_row_start_r = cur_row_start_r;
      v_row_step_q  = cur_row_step_q;
      v_row_step_r  = cur_row_step_r;
    end

    row_hit  = (NPR_W'(v_sr) == v_npr) && (v_orow < v_dh);
    col_hit  = (v_sc < half_width) && (NPC_W'(v_sc) == v_npc) && (v_oc < v_dw);
    hit      = row_hit && col_hit;
    row_end  = FW_W'(v_sc) >= (eff_width - FW_W'(1));
    last_row = FH_W'(v_sr) >= (eff_height - FH_W'(1));
    is_last  = (v_oc == v_dw - OW_W'(1)) && (v_orow == v_dh - OH_W'(1));

    // Quotient/remainder accumulators; the remainder stays below the divisor.
    col_sum  = {1'b0, v_cr} + {1'b0, v_col_step_r};
    col_wrap = col_sum >= (CREM_W+1)'(v_dw);
    npc_adv  = v_npc + NPC_W'(v_col_step_q) + NPC_W'(col_wrap);
    cr_adv   = col_wrap ? CREM_W'(col_sum - (CREM_W+1)'(v_dw)) : col_sum[CREM_W-1:0];

    row_sum  = {1'b0, v_rr} + {1'b0, v_row_step_r};
    row_wrap = row_sum >= (RREM_W+1)'(v_dh);
    npr_adv  = v_npr + NPR_W'(v_row_step_q) + NPR_W'(row_wrap);
    rr_adv   = row_wrap ? RREM_W'(row_sum - (RREM_W+1)'(v_dh)) : row_sum[RREM_W-1:0];

    source_column_next    = v_sc;
    source_row_next       = v_sr;
    output_column_next    = v_oc;
    output_row_next       = v_orow;
    next_pick_column_next = v_npc;
    column_remainder_next = v_cr;
    next_pick_row_next    = v_npr;
    row_remainder_next    = v_rr;

    if (hit) begin
      output_column_next    = v_oc + OW_W'(1);
      next_pick_column_next = npc_adv;
      column_remainder_next = cr_adv;
    end

    if (row_end) begin
      source_column_next    = '0;
      output_column_next    = '0;
      next_pick_column_next = NPC_W'(v_col_start_q);
      column_remainder_next = v_col_start_r;
      if (row_hit) begin
        output_row_next    = v_orow + OROW_W'(1);
        next_pick_row_next = npr_adv;
        row_remainder_next = rr_adv;
      end
      if (last_row) begin
        source_row_next    = '0;
        output_row_next    = '0;
        next_pick_row_next = NPR_W'(v_row_start_q);
        row_remainder_next = v_row_start_r;
      end else begin
        source_row_next = v_sr + SRC_W'(1);
      end
    end else begin
      source_column_next = v_sc + SRC_W'(1);
    end
  end

  // Advance the counters once per pixel that leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_column    <= '0;
      source_row       <= '0;
      next_pick_column <= '0;
      next_pick_row    <= '0;
      output_column    <= '0;
      output_row       <= '0;
      column_remainder <= '0;
      row_remainder    <= '0;
    end else if (pix_go) begin
      source_column    <= source_column_next;
      source_row       <= source_row_next;
      next_pick_column <= next_pick_column_next;
      next_pick_row    <= next_pick_row_next;
      output_column    <= output_column_next;
      output_row       <= output_row_next;
      column_remainder <= column_remainder_next;
      row_remainder    <= row_remainder_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Luma and output register
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]      red, blue;
  logic [LUMA_SUM_W-1:0] luma_sum;

  always_comb begin
    red      = channel_order ? pix_byte_two : pix_byte_zero;
    blue     = channel_order ? pix_byte_zero : pix_byte_two;
    luma_sum = LUMA_R * LUMA_SUM_W'(red) + LUMA_G * LUMA_SUM_W'(pix_byte_one)
             + LUMA_B * LUMA_SUM_W'(blue) + LUMA_ROUND;
  end

  logic result_load;
  assign result_load = pix_go && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      luma.valid <= 1'b0;
    end else if (result_load) begin
      luma.valid <= 1'b1;
    end else if (luma.ready) begin
      luma.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      luma.gray       <= luma_sum[LUMA_SHIFT +: PIX_W];
      luma.out_column <= v_oc;
      luma.out_row    <= v_orow[ROW_OUT_W-1:0];
      luma.frame_end  <= is_last;
    end
  end

`ifndef SYNTHESIS
  // No pixel enters while the division tables are being rebuilt.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pixel.ready)
    else $error("pixel accepted during table rebuild");

  // Accumulator remainders stay below the latched output size.
  a_col_rem_range: assert property (@(posedge clk) disable iff (rst)
    column_remainder < derived_out_width)
    else $error("column remainder out of range");

  a_row_rem_range: assert property (@(posedge clk) disable iff (rst)
    OH_W'(row_remainder) < derived_out_height)
    else $error("row remainder out of range");

  // A picked pixel shows up on the output in the cycle after it is picked.
  a_hit_to_output: assert property (@(posedge clk) disable iff (rst)
    result_load |=> luma.valid)
    else $error("picked pixel lost");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ndl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ndl_pkg for operand widths.
`default_nettype none

module ndl_div import ndl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic [DIV_N_W-1:0] quotient,
  output logic [DIV_D_W-1:0] remainder,
  output logic               done
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W-1:0]   rem;

  logic [DIV_D_W:0]   shifted;
  logic [DIV_D_W:0]   diff;
  logic               fits;
  logic [DIV_D_W-1:0] rem_next;

  // Partial remainder stays below the divisor, so one compare and subtract per bit.
  always_comb begin
    shifted  = {rem, quo[DIV_N_W-1]};
    diff     = shifted - {1'b0, divisor};
    fits     = shifted >= {1'b0, divisor};
    rem_next = fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_N_W);
      end else if (run) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (run) begin
      rem <= rem_next;
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for nearest_downscale_luma_unit: random pixel frames against a built-in
// predictor of the downscale picks and luma math. Needs ndl_pkg, ndl_pix_if and ndl_luma_if.

module tb_top;
  import ndl_pkg::*;

  // Spare register index: the block decodes only three registers, a write here changes nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES   = 4;     // margin over the pixel-to-beat path through input stage and output register
  localparam int RANDOM_PIXELS  = 1250;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [PIX_W-1:0] byte_zero;
    logic [PIX_W-1:0] byte_one;
    logic [PIX_W-1:0] byte_two;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0]     gray;
    logic [COL_OUT_W-1:0] out_column;
    logic [ROW_OUT_W-1:0] out_row;
    logic                 frame_end;
  } luma_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic                 write_enable;
  logic [CFG_IDX_W-1:0] write_index;
  logic [CFG_W-1:0]     write_data;

  ndl_pix_if  pix();
  ndl_luma_if luma();

  nearest_downscale_luma_unit dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixel        (pix),
    .luma         (luma)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor: register copies and sampling state, updated on every accepted pixel beat.
  // Counters are kept 32 bits wide so that register changes in mid-frame cannot wrap them.
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic             cfg_order;

  int unsigned src_col, src_row;     // position of the incoming pixel in the full frame
  int unsigned pick_col, pick_row;   // next source column / row to sample
  int unsigned col_rem, row_rem;     // remainders of the pick accumulators
  int unsigned out_col, out_row;     // position of the next output pixel
  int unsigned out_w, out_h;         // output size latched at frame start

  luma_beat_t expected_luma[$];
  int         mismatch_count = 0;
  int         pixels_sent = 0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;
  int         stall_left = 0;

  function automatic int unsigned clamped_width();
    int unsigned w;
    w = cfg_width;
    if (w < MIN_FRAME_WIDTH) w = MIN_FRAME_WIDTH;
    if (w > MAX_FRAME_WIDTH) w = MAX_FRAME_WIDTH;
    return w;
  endfunction

  function automatic int unsigned clamped_height();
    int unsigned h;
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    return h;
  endfunction

  // Place the first pick of a row / frame at the rounded center of its source span
  function automatic void restart_columns();
    int unsigned span;
    span = (clamped_width() >> 1) >> 1;
    pick_col = span / out_w;
    col_rem  = span % out_w;
  endfunction

  function automatic void restart_rows();
    int unsigned span;
    span = clamped_height() >> 1;
    pick_row = span / out_h;
    row_rem  = span % out_h;
  endfunction

  function automatic void advance_pick_column();
    int unsigned sw;
    sw = clamped_width() >> 1;
    pick_col += sw / out_w;
    col_rem  += sw % out_w;
    if (col_rem >= out_w) begin
      col_rem -= out_w;
      pick_col++;
    end
  endfunction

  function automatic void advance_pick_row();
    int unsigned h;
    h = clamped_height();
    pick_row += h / out_h;
    row_rem  += h % out_h;
    if (row_rem >= out_h) begin
      row_rem -= out_h;
      pick_row++;
    end
  endfunction

  // Latch the output size from the registers as they stand, clear all counters
  function automatic void start_frame();
    int unsigned sw, w, h;
    sw = clamped_width() >> 1;
    w  = (sw < MAX_OUT_WIDTH) ? sw : MAX_OUT_WIDTH;
    h  = (clamped_height() * w + (sw >> 1)) / sw;
    out_w   = (w < 1) ? 1 : w;
    out_h   = (h < 1) ? 1 : h;
    src_col = 0;
    src_row = 0;
    out_col = 0;
    out_row = 0;
    restart_columns();
    restart_rows();
  endfunction

  function automatic void reset_predictor();
    cfg_width  = CFG_W'(2);
    cfg_height = CFG_W'(1);
    cfg_order  = 1'b0;
    src_col  = 0;
    src_row  = 0;
    pick_col = 0;
    pick_row = 0;
    out_col  = 0;
    out_row  = 0;
    col_rem  = 0;
    row_rem  = 0;
    out_w    = 1;
    out_h    = 1;
  endfunction

  // Returns 1 when the pixel is a sampled one, with its beat in sample
  function automatic bit downscale_pixel(input pixel_t px, output luma_beat_t sample);
    int unsigned fw, fh, red, blue, sum;
    bit row_hit, col_hit;
    if (px.frame_start) start_frame();
    fw   = clamped_width();
    fh   = clamped_height();
    red  = cfg_order ? px.byte_two : px.byte_zero;
    blue = cfg_order ? px.byte_zero : px.byte_two;
    row_hit = (src_row == pick_row) && (out_row < out_h);
    col_hit = (src_col < (fw >> 1)) && (src_col == pick_col) && (out_col < out_w);
    sample = '0;
    if (row_hit && col_hit) begin
      sum = LUMA_R * red + LUMA_G * px.byte_one + LUMA_B * blue + LUMA_ROUND;
      sample.gray       = PIX_W'(sum >> LUMA_SHIFT);
      sample.out_column = COL_OUT_W'(out_col);
      sample.out_row    = ROW_OUT_W'(out_row);
      sample.frame_end  = (out_col == out_w - 1) && (out_row == out_h - 1);
      out_col++;
      advance_pick_column();
    end
    // Row end: step the row pick only if this row was a sampled one, wrap at the last row
    if (src_col >= fw - 1) begin
      if (row_hit) begin
        out_row++;
        advance_pick_row();
      end
      src_col = 0;
      out_col = 0;
      restart_columns();
      if (src_row >= fh - 1) begin
        src_row = 0;
        out_row = 0;
        restart_rows();
      end else begin
        src_row++;
      end
    end else begin
      src_col++;
    end
    return row_hit && col_hit;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Idle lengths for both sides: mostly none, some short, a few long
  // ---------------------------------------------------------------------------------------
  function automatic int idle_length(input bit enabled);
    if (!enabled || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Luma side: drive ready, holding it low for a random stall now and then
  initial begin
    luma.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) stall_left = idle_length(stalls_on);
      if (stall_left != 0) begin
        luma.ready <= 1'b0;
        stall_left--;
      end else begin
        luma.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted luma beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && luma.valid && luma.ready) begin
      if (expected_luma.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected luma beat: gray %0d col %0d row %0d end %0b", $realtime,
                   luma.gray, luma.out_column, luma.out_row, luma.frame_end);
      end else begin
        luma_beat_t want;
        want = expected_luma.pop_front();
        if (luma.gray !== want.gray || luma.out_column !== want.out_column ||
            luma.out_row !== want.out_row || luma.frame_end !== want.frame_end) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: luma mismatch: expected gray %0d col %0d row %0d end %0b, ",
                      "got gray %0d col %0d row %0d end %0b"},
                     $realtime, want.gray, want.out_column, want.out_row, want.frame_end,
                     luma.gray, luma.out_column, luma.out_row, luma.frame_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus tasks. Each one starts and ends just after a rising edge.
  // ---------------------------------------------------------------------------------------

  // Offer one pixel beat, hold it until accepted, then predict its outcome
  task automatic send_pixel(input pixel_t px);
    luma_beat_t sample;
    int gap;
    gap = idle_length(gaps_on);
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.byte_zero   <= px.byte_zero;
    pix.byte_one    <= px.byte_one;
    pix.byte_two    <= px.byte_two;
    pix.frame_start <= px.frame_start;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pixels_sent++;
    if (downscale_pixel(px, sample)) expected_luma.push_back(sample);
  endtask

  task automatic send_color(input int b0, input int b1, input int b2, input bit start);
    pixel_t px;
    px.byte_zero   = PIX_W'(b0);
    px.byte_one    = PIX_W'(b1);
    px.byte_two    = PIX_W'(b2);
    px.frame_start = start;
    send_pixel(px);
  endtask

  // Random colors; frame_start only on the first beat when asked
  task automatic send_run(input int count, input bit start_first);
    for (int i = 0; i < count; i++)
      send_color($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 start_first && i == 0);
  endtask

  // Drop valid, let every predicted beat come out, then give the pipeline time to empty
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (expected_luma.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; the block holds pixel ready low for its table rebuild afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    write_enable <= 1'b1;
    write_index  <= index;
    write_data   <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    case (index)
      REG_FRAME_WIDTH:   cfg_width  = data;
      REG_FRAME_HEIGHT:  cfg_height = data;
      REG_CHANNEL_ORDER: cfg_order  = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Channel order goes in with random upper bits, which the block must ignore
  task automatic configure(input int width, input int height, input bit order);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(width));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(height));
    write_reg(REG_CHANNEL_ORDER, {(CFG_W-1)'($urandom_range(0, 8191)), order});
  endtask

  // Mostly small frames; now and then a frame wide enough to hit the output width cap,
  // and rarely anything the 14-bit registers can hold
  task automatic random_config();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      configure($urandom_range(2, 24), $urandom_range(1, 10), $urandom_range(0, 1));
    else if (r < 95)
      configure($urandom_range(1281, 1300), $urandom_range(1, 3), $urandom_range(0, 1));
    else
      configure($urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 1));
  endtask

  // Whole frame when small, else only a prefix of it
  function automatic int frame_length();
    int unsigned frame_pixels;
    frame_pixels = clamped_width() * clamped_height();
    if (frame_pixels > 300) return $urandom_range(20, 150);
    return frame_pixels;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset values give one sampled pixel per two-pixel frame; run without any frame_start
  task automatic test_reset_state();
    send_color(255, 255, 255, 1'b0);
    send_color(0, 0, 0, 1'b0);
    send_color($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
  endtask

  // Pure primaries, so a swapped red/blue weight shows up in the gray value
  task automatic test_channel_order();
    configure(2, 2, 1'b1);
    send_color(255, 0, 0, 1'b1);
    send_color(0, 255, 0, 1'b0);
    send_color(0, 0, 255, 1'b0);
    send_color(255, 255, 255, 1'b0);
    configure(2, 2, 1'b0);
  endtask

  // Zero registers clamp up, oversized ones clamp down, an odd width gives its extra
  // column to the right half, and the spare index is written once
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_SPARE, CFG_W'($urandom_range(0, 16383)));
    configure(0, 0, 1'b0);
    send_run(2, 1'b1);
    configure(16383, 1, 1'b1);
    send_run(10, 1'b1);
    configure(3, 16383, 1'b0);
    send_run(6, 1'b1);
    configure(MAX_FRAME_WIDTH, ROW_LIMIT, 1'b1);
    send_run(4, 1'b1);
  endtask

  task automatic test_random_frames();
    int target, kind, frames;
    target = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < target) begin
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        // Well-formed frames; later ones either restart or wrap on their own
        random_config();
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
          send_run(frame_length(), f == 0 || $urandom_range(0, 1) == 1);
      end else if (kind < 85) begin
        // Noise: frame_start at random places, often in mid-frame
        if ($urandom_range(0, 1) == 1) random_config();
        for (int i = 0; i < $urandom_range(5, 40); i++)
          send_color($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 7) == 0);
      end else begin
        // Register change in mid-frame; the latched output size stays as it was
        configure($urandom_range(2, 24), $urandom_range(1, 10), $urandom_range(0, 1));
        send_run($urandom_range(1, frame_length()), 1'b1);
        wait_idle();
        case ($urandom_range(0, 3))
          0: write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(2, 24)));
          1: write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(1, 10)));
          2: write_reg(REG_CHANNEL_ORDER, CFG_W'($urandom_range(0, 1)));
          default: write_reg(REG_SPARE, CFG_W'($urandom_range(0, 16383)));
        endcase
        send_run($urandom_range(5, 40), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    write_enable    <= 1'b0;
    write_index     <= REG_FRAME_WIDTH;
    write_data      <= '0;
    pix.valid       <= 1'b0;
    pix.byte_zero   <= '0;
    pix.byte_one    <= '0;
    pix.byte_two    <= '0;
    pix.frame_start <= 1'b0;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_channel_order();
    test_register_extremes();
    test_random_frames();

    // Drain: wait for outstanding beats with a bound, then watch for strays
    pix.valid <= 1'b0;
    for (int i = 0; i < 5000 && expected_luma.size() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (expected_luma.size() != 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0d predicted luma beats never arrived", expected_luma.size());
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ndl_pkg.sv
hw/rtl/ndl_pix_if.sv
hw/rtl/ndl_luma_if.sv
hw/rtl/ndl_div.sv
hw/rtl/nearest_downscale_luma_unit.sv
bench/tb_top.sv
